FILE: rtl/mms_pkg.sv
package mms_pkg;

  // operation codes on in_operation
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam int unsigned RESULT_W = 32;
  localparam int unsigned COUNT_W  = 7;

  // command class decided by the front end
  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_REMOVE,
    CMD_SEARCH,
    CMD_BAD
  } cmd_kind_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic      valid;
    cmd_kind_t kind;
  } q_head_t;

endpackage

FILE: rtl/mms_ram.sv
module mms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/mms_front.sv
module mms_front import mms_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_operation,
  input  logic signed [31:0]    in_pair_key,
  input  logic signed [31:0]    in_pair_value,
  output q_head_t               head,
  output logic [DATA_WIDTH-1:0] head_key,
  output logic [DATA_WIDTH-1:0] head_value,
  input  logic                  pop
);

  // two-entry queue, 1-bit pointers
  cmd_kind_t             kind_mem [2];
  logic [DATA_WIDTH-1:0] key_mem  [2];
  logic [DATA_WIDTH-1:0] val_mem  [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            fill_r, fill_nxt;
  logic                  full;
  logic                  push;
  cmd_kind_t             kind_in;

  always_comb begin
    case (in_operation)
      OP_ADD:    kind_in = CMD_ADD;
      OP_REMOVE: kind_in = CMD_REMOVE;
      OP_SEARCH: kind_in = CMD_SEARCH;
      default:   kind_in = CMD_BAD;
    endcase
  end

  assign full = (fill_r == 2'd2);
  assign busy = full;
  assign push = start && !full;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // keys and values kept sign-extended or truncated to DATA_WIDTH
  always_ff @(posedge clk) begin
    if (push) begin
      kind_mem[wr_ptr_r] <= kind_in;
      key_mem[wr_ptr_r]  <= DATA_WIDTH'(in_pair_key);
      val_mem[wr_ptr_r]  <= DATA_WIDTH'(in_pair_value);
    end
  end

  assign head.valid = (fill_r != 2'd0);
  assign head.kind  = kind_mem[rd_ptr_r];
  assign head_key   = key_mem[rd_ptr_r];
  assign head_value = val_mem[rd_ptr_r];

endmodule

FILE: rtl/mms_back.sv
module mms_back import mms_pkg::*; #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  q_head_t               head,
  input  logic [DATA_WIDTH-1:0] head_key,
  input  logic [DATA_WIDTH-1:0] head_value,
  output logic                  pop,
  output logic                  out_strobe,
  output logic [1:0]            out_status,
  output logic signed [31:0]    out_found_value,
  output logic                  out_last_result,
  output logic [6:0]            out_pair_count
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FLUSH
  } state_t;

  state_t                state_r, state_nxt;
  cmd_kind_t             kind_r, kind_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [DATA_WIDTH-1:0] pend_r, pend_nxt;
  logic                  have_pend_r, have_pend_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;

  logic                  strobe_r, strobe_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [RESULT_W-1:0]   fval_r, fval_nxt;
  logic                  last_r, last_nxt;
  logic [CNT_W-1:0]      ocount_r, ocount_nxt;

  logic                  we;
  logic [IDX_W-1:0]      waddr, raddr;
  logic [DATA_WIDTH-1:0] wkey, wval, rkey, rval;
  logic                  at_end, key_hit, pair_hit;

  mms_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_keys (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wkey),
    .raddr (raddr),
    .rdata (rkey)
  );

  mms_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_vals (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wval),
    .raddr (raddr),
    .rdata (rval)
  );

  // read data always belongs to entry ptr_r while scanning or shifting
  assign raddr    = (state_r == S_IDLE) ? '0 : ptr_r + IDX_W'(1);
  assign at_end   = ((CNT_W'(ptr_r) + CNT_W'(1)) == count_r);
  assign key_hit  = (rkey == key_r);
  assign pair_hit = key_hit && (rval == val_r);

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    pend_nxt      = pend_r;
    have_pend_nxt = have_pend_r;
    ptr_nxt       = ptr_r;
    count_nxt     = count_r;
    strobe_nxt    = 1'b0;
    status_nxt    = status_r;
    fval_nxt      = fval_r;
    last_nxt      = last_r;
    ocount_nxt    = ocount_r;
    pop           = 1'b0;
    we            = 1'b0;
    waddr         = count_r[IDX_W-1:0];
    wkey          = head_key;
    wval          = head_value;

    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop           = 1'b1;
          kind_nxt      = head.kind;
          key_nxt       = head_key;
          val_nxt       = head_value;
          ptr_nxt       = '0;
          have_pend_nxt = 1'b0;
          strobe_nxt    = 1'b1;
          fval_nxt      = '0;
          last_nxt      = 1'b1;
          ocount_nxt    = count_r;
          case (head.kind)
            CMD_ADD: begin
              if (count_r >= CAP_CNT) begin
                status_nxt = ST_FULL;
              end else begin
                we         = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
                ocount_nxt = count_r + CNT_W'(1);
                status_nxt = ST_OK;
              end
            end
            CMD_REMOVE, CMD_SEARCH: begin
              if (count_r == '0) begin
                status_nxt = ST_MISSING;
              end else begin
                strobe_nxt = 1'b0;
                state_nxt  = S_SCAN;
              end
            end
            default: begin
              status_nxt = ST_MISSING;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (kind_r == CMD_REMOVE) begin
          if (pair_hit) begin
            if (at_end) begin
              count_nxt  = count_r - CNT_W'(1);
              strobe_nxt = 1'b1;
              status_nxt = ST_OK;
              fval_nxt   = '0;
              last_nxt   = 1'b1;
              ocount_nxt = count_r - CNT_W'(1);
              state_nxt  = S_IDLE;
            end else begin
              ptr_nxt   = ptr_r + IDX_W'(1);
              state_nxt = S_SHIFT;
            end
          end else if (at_end) begin
            strobe_nxt = 1'b1;
            status_nxt = ST_MISSING;
            fval_nxt   = '0;
            last_nxt   = 1'b1;
            ocount_nxt = count_r;
            state_nxt  = S_IDLE;
          end else begin
            ptr_nxt = ptr_r + IDX_W'(1);
          end
        end else begin
          // hold one match back so the final one can be marked last
          if (key_hit) begin
            if (have_pend_r) begin
              strobe_nxt = 1'b1;
              status_nxt = ST_OK;
              fval_nxt   = RESULT_W'(pend_r);
              last_nxt   = 1'b0;
              ocount_nxt = count_r;
            end
            pend_nxt      = rval;
            have_pend_nxt = 1'b1;
          end
          if (at_end) begin
            state_nxt = S_FLUSH;
          end else begin
            ptr_nxt = ptr_r + IDX_W'(1);
          end
        end
      end

      S_SHIFT: begin
        we    = 1'b1;
        waddr = ptr_r - IDX_W'(1);
        wkey  = rkey;
        wval  = rval;
        if (at_end) begin
          count_nxt  = count_r - CNT_W'(1);
          strobe_nxt = 1'b1;
          status_nxt = ST_OK;
          fval_nxt   = '0;
          last_nxt   = 1'b1;
          ocount_nxt = count_r - CNT_W'(1);
          state_nxt  = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + IDX_W'(1);
        end
      end

      S_FLUSH: begin
        strobe_nxt = 1'b1;
        last_nxt   = 1'b1;
        ocount_nxt = count_r;
        if (have_pend_r) begin
          status_nxt = ST_OK;
          fval_nxt   = RESULT_W'(pend_r);
        end else begin
          status_nxt = ST_MISSING;
          fval_nxt   = '0;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      strobe_r    <= 1'b0;
      have_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      strobe_r    <= strobe_nxt;
      have_pend_r <= have_pend_nxt;
    end
    kind_r   <= kind_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    pend_r   <= pend_nxt;
    ptr_r    <= ptr_nxt;
    status_r <= status_nxt;
    fval_r   <= fval_nxt;
    last_r   <= last_nxt;
    ocount_r <= ocount_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_found_value = fval_r;
  assign out_last_result = last_r;
  assign out_pair_count  = COUNT_W'(ocount_r);

endmodule

FILE: rtl/multimap_store_top.sv
// Bounded multimap of key/value pairs; one key may hold many values. A
// transaction is taken when start is high and busy is low. Operation 0 appends
// the pair (status full when CAPACITY pairs are held), 1 removes the first
// pair matching key and value and closes the gap, 2 returns every value of
// the key in insertion order with out_last_result on the final one. A missing
// pair or key, or an unused operation code, gives one result with status
// not-found. Every result carries the pair count after the operation. Results
// appear on the out_ ports for exactly one cycle with out_strobe high; the
// receiver cannot stall them, so take every strobe. A two-entry queue sits
// after the input, so busy rises only when two transactions wait behind the
// one being executed. With N the pairs stored: an add or an invalid code is
// decided when the execution unit pops it; search walks all N pairs (an empty
// store answers at once) and emits one result per match, the last after the
// scan; remove walks to the match, then shifts each later pair down one entry,
// or walks all N pairs when nothing matches. The key and value tables are
// walked one entry per cycle, and the next transaction is popped only in
// idle. A result is registered and leaves in the cycle after the step that
// decides it. No clearing pass follows reset.
module multimap_store_top import mms_pkg::*; #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_pair_key,
  input  logic signed [31:0] in_pair_value,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_found_value,
  output logic               out_last_result,
  output logic [6:0]         out_pair_count
);

  // queue head handed from front end to execution unit
  q_head_t               head;
  logic [DATA_WIDTH-1:0] head_key;
  logic [DATA_WIDTH-1:0] head_value;
  logic                  pop;

  // front end: decodes the operation and queues the transaction
  mms_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_pair_key   (in_pair_key),
    .in_pair_value (in_pair_value),
    .head          (head),
    .head_key      (head_key),
    .head_value    (head_value),
    .pop           (pop)
  );

  // execution unit: owns the compacted pair table and the pair count
  mms_back #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_key        (head_key),
    .head_value      (head_value),
    .pop             (pop),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_last_result (out_last_result),
    .out_pair_count  (out_pair_count)
  );

endmodule
